### rtl/core/msrp_pkg.sv
// Shared types, character codes and sizes for the MSRP message framer.
package msrp_pkg;

	localparam int IDENT_MAX   = 32;
	localparam int IDX_W       = $clog2(IDENT_MAX);
	localparam int LEN_W       = $clog2(IDENT_MAX + 1);
	localparam int MC_W        = $clog2(IDENT_MAX + 3);
	localparam int COUNT_BITS  = 24;
	localparam int HIST_DEPTH  = 8;
	localparam int PREFIX_LEN  = 4;
	localparam int DASH_RUN    = 7;
	localparam int BODY_TRAIL  = 9;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CASE_BIT  = 8'h20;

	// lower-case "msrp"
	localparam logic [7:0] PFX_CHARS [PREFIX_LEN] = '{8'h6D, 8'h73, 8'h72, 8'h70};

	localparam logic [1:0] FLAG_NONE   = 2'd0;
	localparam logic [1:0] FLAG_PLUS   = 2'd1;
	localparam logic [1:0] FLAG_DOLLAR = 2'd2;
	localparam logic [1:0] FLAG_HASH   = 2'd3;

	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_ID    = 3'd1,
		EV_LINE  = 3'd2,
		EV_BODY  = 3'd3,
		EV_DONE  = 3'd4,
		EV_ERROR = 3'd5
	} event_t;

	typedef enum logic [3:0] {
		PH_PREFIX  = 4'd0,
		PH_IDFIRST = 4'd1,
		PH_IDENT   = 4'd2,
		PH_METHOD  = 4'd3,
		PH_HEADERS = 4'd4,
		PH_HDRDASH = 4'd5,
		PH_BODY    = 4'd6,
		PH_ENDID   = 4'd7,
		PH_ERROR   = 4'd8
	} phase_t;

	// classified input byte, front to back
	typedef struct packed {
		logic                  restart;
		logic [7:0]            data;
		logic                  is_space;
		logic                  is_alnum;
		logic                  is_cr;
		logic                  is_lf;
		logic                  is_dash;
		logic [1:0]            flag;
		logic [PREFIX_LEN-1:0] pfx_hit;
	} item_t;

	// byte class kept in the history window
	typedef struct packed {
		logic cr;
		logic lf;
		logic dash;
	} hcls_t;

	typedef struct packed {
		event_t                ev;
		logic [1:0]            flag;
		logic [LEN_W-1:0]      idl;
		logic [COUNT_BITS-1:0] body;
		logic [COUNT_BITS-1:0] msg;
	} res_t;

endpackage

### rtl/core/msrp_if.sv
// Valid/ready channel interfaces for the byte input and the result output.
interface msrp_byte_if;
	import msrp_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       restart;
	modport source(output valid, output data_byte, output restart, input ready);
	modport sink(input valid, input data_byte, input restart, output ready);
endinterface

interface msrp_result_if;
	import msrp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [2:0]            event_res;
	logic [1:0]            cont_flag;
	logic [LEN_W-1:0]      ident_length;
	logic [COUNT_BITS-1:0] body_length;
	logic [COUNT_BITS-1:0] message_length;
	modport source(output valid, output event_res, output cont_flag, output ident_length,
		output body_length, output message_length, input ready);
	modport sink(input valid, input event_res, input cont_flag, input ident_length,
		input body_length, input message_length, output ready);
endinterface

### rtl/core/msrp_front.sv
// Front end: accepts stream bytes and classifies them for the parser.
module msrp_front (
	msrp_byte_if.sink        rx,
	output logic             push_valid,
	output msrp_pkg::item_t  push_item,
	input  logic             push_ready
);
	import msrp_pkg::*;

	logic [7:0] b;

	assign b          = rx.data_byte;
	assign push_valid = rx.valid;
	assign rx.ready   = push_ready;

	always_comb begin
		push_item          = '0;
		push_item.restart  = rx.restart;
		push_item.data     = b;
		push_item.is_space = (b == CH_SPACE);
		// digits, upper and lower case letters
		push_item.is_alnum = b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
		push_item.is_cr    = (b == CH_CR);
		push_item.is_lf    = (b == CH_LF);
		push_item.is_dash  = (b == CH_DASH);
		case (b)
			CH_PLUS:   push_item.flag = FLAG_PLUS;
			CH_DOLLAR: push_item.flag = FLAG_DOLLAR;
			CH_HASH:   push_item.flag = FLAG_HASH;
			default:   push_item.flag = FLAG_NONE;
		endcase
		for (int i = 0; i < PREFIX_LEN; i++) begin
			push_item.pfx_hit[i] = ((b | CASE_BIT) == PFX_CHARS[i]);
		end
	end

endmodule

### rtl/core/msrp_queue.sv
// Short queue of classified bytes between front and back.
module msrp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  msrp_pkg::item_t  push_item,
	output logic             push_ready,
	output logic             pop_valid,
	output msrp_pkg::item_t  pop_item,
	input  logic             pop_ready
);
	import msrp_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign push_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/core/msrp_back.sv
// Back end: message parser state machine, id store, counters and result register.
module msrp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  msrp_pkg::item_t   item,
	output logic              item_ready,
	msrp_result_if.source     res
);
	import msrp_pkg::*;

	phase_t                phase_q, phase_d, phase_b;
	logic [MC_W-1:0]       mc_q, mc_d, mc_b;
	hcls_t [HIST_DEPTH-1:0] hist_q, hist_d, hist_b;
	logic [LEN_W-1:0]      ilen_q, ilen_d, ilen_b;
	logic [COUNT_BITS-1:0] bcnt_q, bcnt_d, bcnt_b;
	logic [COUNT_BITS-1:0] mcnt_q, mcnt_d, mcnt_b;
	logic [1:0]            flag_q, flag_d, flag_b;
	logic [7:0]            ident_q [IDENT_MAX];
	logic                  id_we;
	logic [IDX_W-1:0]      id_wa;
	logic [7:0]            id_rd;
	hcls_t                 cur;
	logic                  hit;
	logic                  adv;
	logic                  out_valid_q;
	res_t                  out_q, res_d;

	assign adv        = item_valid && (!out_valid_q || res.ready);
	assign item_ready = !out_valid_q || res.ready;

	// restart clears the parser before the byte is taken
	assign phase_b = item.restart ? PH_PREFIX  : phase_q;
	assign mc_b    = item.restart ? '0         : mc_q;
	assign hist_b  = item.restart ? '0         : hist_q;
	assign ilen_b  = item.restart ? '0         : ilen_q;
	assign bcnt_b  = item.restart ? '0         : bcnt_q;
	assign mcnt_b  = item.restart ? '0         : mcnt_q;
	assign flag_b  = item.restart ? FLAG_NONE  : flag_q;

	assign cur   = '{cr: item.is_cr, lf: item.is_lf, dash: item.is_dash};
	assign id_rd = ident_q[mc_b[IDX_W-1:0]];

	// end-line in the body: CRLF then seven dashes, newest byte last
	always_comb begin
		hit = hist_b[7].cr && hist_b[6].lf && cur.dash;
		for (int k = 0; k < DASH_RUN - 1; k++) begin
			hit = hit && hist_b[k].dash;
		end
	end

	always_comb begin
		phase_d  = phase_b;
		mc_d     = mc_b;
		hist_d   = {hist_b[HIST_DEPTH-2:0], cur};
		ilen_d   = ilen_b;
		bcnt_d   = bcnt_b;
		mcnt_d   = mcnt_b;
		flag_d   = flag_b;
		id_we    = 1'b0;
		id_wa    = ilen_b[IDX_W-1:0];
		res_d    = '0;
		res_d.ev = EV_NONE;
		if (mcnt_b != COUNT_MAX) begin
			mcnt_d = mcnt_b + 1'b1;
		end
		case (phase_b)
			PH_PREFIX: begin
				if (mc_b < MC_W'(PREFIX_LEN)) begin
					if (item.pfx_hit[mc_b[$clog2(PREFIX_LEN)-1:0]]) begin
						mc_d = mc_b + 1'b1;
					end else begin
						res_d.ev = EV_ERROR;
					end
				end else if (item.is_space) begin
					phase_d = PH_IDFIRST;
					mc_d    = '0;
					hist_d  = '0;
				end else begin
					res_d.ev = EV_ERROR;
				end
			end
			PH_IDFIRST: begin
				if (item.is_alnum) begin
					id_we   = 1'b1;
					id_wa   = '0;
					ilen_d  = LEN_W'(1);
					phase_d = PH_IDENT;
					mc_d    = '0;
					hist_d  = '0;
				end else begin
					res_d.ev = EV_ERROR;
				end
			end
			PH_IDENT: begin
				if (item.is_space) begin
					res_d.ev = EV_ID;
					phase_d  = PH_METHOD;
					mc_d     = '0;
					hist_d   = '0;
				end else if (ilen_b >= LEN_W'(IDENT_MAX)) begin
					res_d.ev = EV_ERROR;
				end else begin
					id_we  = 1'b1;
					ilen_d = ilen_b + 1'b1;
				end
			end
			PH_METHOD: begin
				if (hist_b[0].cr && cur.lf) begin
					res_d.ev = EV_LINE;
					phase_d  = PH_HEADERS;
					mc_d     = '0;
					hist_d   = '0;
				end
			end
			PH_HEADERS: begin
				if (hist_b[2].cr && hist_b[1].lf) begin
					if (hist_b[0].cr && cur.lf) begin
						res_d.ev = EV_BODY;
						bcnt_d   = '0;
						phase_d  = PH_BODY;
						mc_d     = '0;
						hist_d   = '0;
					end else if (hist_b[0].dash && cur.dash) begin
						phase_d = PH_HDRDASH;
						mc_d    = MC_W'(2);
						hist_d  = '0;
					end
				end
			end
			PH_HDRDASH: begin
				if (cur.dash) begin
					mc_d = mc_b + 1'b1;
					if (mc_d >= MC_W'(DASH_RUN)) begin
						phase_d = PH_ENDID;
						mc_d    = '0;
						hist_d  = '0;
					end
				end else begin
					res_d.ev = EV_ERROR;
				end
			end
			PH_BODY: begin
				if (bcnt_b != COUNT_MAX) begin
					bcnt_d = bcnt_b + 1'b1;
				end
				if (hit) begin
					// drop the CRLF and seven dashes already counted
					if (bcnt_d != COUNT_MAX) begin
						bcnt_d = bcnt_d - COUNT_BITS'(BODY_TRAIL);
					end
					phase_d = PH_ENDID;
					mc_d    = '0;
					hist_d  = '0;
				end
			end
			PH_ENDID: begin
				if (MC_W'(ilen_b) > mc_b) begin
					if (item.data == id_rd) begin
						mc_d = mc_b + 1'b1;
					end else begin
						res_d.ev = EV_ERROR;
					end
				end else if (mc_b == MC_W'(ilen_b)) begin
					if (item.flag != FLAG_NONE) begin
						flag_d = item.flag;
					end else begin
						res_d.ev = EV_ERROR;
					end
					mc_d = mc_b + 1'b1;
				end else if (mc_b == MC_W'(ilen_b) + 1'b1) begin
					if (item.is_cr) begin
						mc_d = mc_b + 1'b1;
					end else begin
						res_d.ev = EV_ERROR;
					end
				end else begin
					if (item.is_lf) begin
						res_d.ev   = EV_DONE;
						res_d.flag = flag_b;
						res_d.body = bcnt_b;
					end else begin
						res_d.ev = EV_ERROR;
					end
				end
			end
			default: begin
				res_d.ev = EV_ERROR;
			end
		endcase
		if (res_d.ev == EV_ERROR) begin
			phase_d = PH_ERROR;
		end
		res_d.idl = ilen_d;
		res_d.msg = mcnt_d;
		// completed message: next byte opens a fresh one
		if (res_d.ev == EV_DONE) begin
			phase_d = PH_PREFIX;
			mc_d    = '0;
			hist_d  = '0;
			ilen_d  = '0;
			bcnt_d  = '0;
			mcnt_d  = '0;
			flag_d  = FLAG_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && id_we) begin
			ident_q[id_wa] <= item.data;
		end
		if (adv) begin
			out_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PREFIX;
			mc_q        <= '0;
			hist_q      <= '0;
			ilen_q      <= '0;
			bcnt_q      <= '0;
			mcnt_q      <= '0;
			flag_q      <= FLAG_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				phase_q <= phase_d;
				mc_q    <= mc_d;
				hist_q  <= hist_d;
				ilen_q  <= ilen_d;
				bcnt_q  <= bcnt_d;
				mcnt_q  <= mcnt_d;
				flag_q  <= flag_d;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid          = out_valid_q;
	assign res.event_res      = out_q.ev;
	assign res.cont_flag      = out_q.flag;
	assign res.ident_length   = out_q.idl;
	assign res.body_length    = out_q.body;
	assign res.message_length = out_q.msg;

endmodule

### rtl/core/msrp_message_framer.sv
// MSRP message framer top level: classifier, byte queue and parser with result register.
// Path: an accepted byte is stored in the queue, and the parser then registers its result.
// Throughput: one byte per cycle; the parser takes one queued byte whenever its result
// register is empty or being drained, and the two-entry queue absorbs output stalls.
// Reset: arst_n clears the queue, parser state, counters and result valid; the id store
// holds no reset value and is written before it is read.
module msrp_message_framer (
	input  logic          clk,
	input  logic          arst_n,
	msrp_byte_if.sink     rx,
	msrp_result_if.source res
);
	import msrp_pkg::*;

	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	msrp_front u_front (
		.rx         (rx),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	msrp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	msrp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (pop_valid),
		.item       (pop_item),
		.item_ready (pop_ready),
		.res        (res)
	);

endmodule

### rtl/core/msrp_framer_chk.sv
// Port-level checks on the framer's result channel, bound to the top level.
module msrp_framer_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            res_valid,
	input logic                            res_ready,
	input logic [2:0]                      event_res,
	input logic [1:0]                      cont_flag,
	input logic [msrp_pkg::LEN_W-1:0]      ident_length,
	input logic [msrp_pkg::COUNT_BITS-1:0] body_length,
	input logic [msrp_pkg::COUNT_BITS-1:0] message_length
);
	import msrp_pkg::*;

	a_done_has_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_res == EV_DONE |-> cont_flag != FLAG_NONE)
		else $error("completed message without continuation flag");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_res != EV_DONE |-> cont_flag == FLAG_NONE && body_length == '0)
		else $error("flag or body length outside completion");

	a_ident_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ident_length <= LEN_W'(IDENT_MAX))
		else $error("id length beyond limit");

	a_msg_counts: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> message_length != '0)
		else $error("result without counted byte");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(event_res) && $stable(message_length))
		else $error("stalled result changed");

endmodule

bind msrp_message_framer msrp_framer_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.event_res      (res.event_res),
	.cont_flag      (res.cont_flag),
	.ident_length   (res.ident_length),
	.body_length    (res.body_length),
	.message_length (res.message_length)
);
